FILE: rtl/fdqm_pkg.sv
// shared widths, register codes, defaults and unit interface types of the divergence meter
package fdqm_pkg;

    localparam int FRAME_DEPTH_DEF = 4096;

    localparam int FEAT_W     = 16;
    localparam int EXP_W      = 16;
    localparam int QUAL_W     = 16;
    localparam int DEG_W      = 2;
    localparam int LOG_W      = 16;
    localparam int LOG_FRAC_W = 12;
    localparam int LOG_INT_W  = LOG_W - LOG_FRAC_W;
    localparam int SUM_W      = 17;
    localparam int MAG_W      = 16;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // output item layout
    localparam int EXP_LSB  = 0;
    localparam int QUAL_LSB = 16;
    localparam int STAB_BIT = 32;
    localparam int DEG_LSB  = 33;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STAB_W     = 15;
    localparam int WEIGHT_W   = 9;
    localparam int MINP_W     = 13;
    localparam int LIMIT_W    = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_STAB_LIMIT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_POINTS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MILD_LIMIT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SEVERE_LIMIT = 3'd4;

    localparam logic [STAB_W-1:0]   STAB_LIMIT_RST  = 15'd41;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST      = 9'd77;
    localparam logic [MINP_W-1:0]   MIN_POINTS_RST  = 13'd16;
    localparam logic [LIMIT_W-1:0]  MILD_LIMIT_RST  = 16'd31130;
    localparam logic [LIMIT_W-1:0]  SEVERE_LIMIT_RST = 16'd27853;

    localparam logic [QUAL_W-1:0] QUAL_ONE = 16'd32768;

    localparam logic [DEG_W-1:0] DEG_NONE   = 2'd0;
    localparam logic [DEG_W-1:0] DEG_MILD   = 2'd1;
    localparam logic [DEG_W-1:0] DEG_SEVERE = 2'd2;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  delta;
    } t_log_req;

    typedef struct packed {
        logic              done;
        logic [LOG_W-1:0]  value;
    } t_log_rsp;

endpackage

FILE: rtl/fdqm_ram.sv
// generic single-port ram, read-first, registered read
module fdqm_ram #(
    parameter int W = 16,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [0:D-1];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fdqm_log2.sv
// iterative log2 unit, q4.12 result, one squaring of the mantissa per cycle
module fdqm_log2 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fdqm_pkg::t_log_req  i_req,
    output fdqm_pkg::t_log_rsp  o_rsp
);

    import fdqm_pkg::*;

    localparam int M_W   = 31;
    localparam int CNT_W = $clog2(LOG_FRAC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LOG_FRAC_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [M_W-1:0]        r_m;
    logic [LOG_FRAC_W-1:0] r_frac;
    logic [LOG_INT_W-1:0]  r_int;

    logic [LOG_INT_W-1:0]  top_bit;
    logic [M_W-1:0]        m_init;
    logic [2*M_W-1:0]      sq;
    logic [M_W:0]          sq_hi;
    logic [M_W-1:0]        n_m;
    logic                  frac_bit;

    // index of the leading one
    always_comb begin
        top_bit = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (i_req.delta[i]) begin
                top_bit = LOG_INT_W'(i);
            end
        end
    end

    // normalize to q1.30
    assign m_init = M_W'({15'd0, i_req.delta} << (5'd30 - 5'(top_bit)));

    assign sq       = 62'(r_m) * 62'(r_m);
    assign sq_hi    = sq[2*M_W-1:M_W-1];
    assign frac_bit = sq_hi[M_W];
    assign n_m      = frac_bit ? sq_hi[M_W:1] : sq_hi[M_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m    <= m_init;
            r_int  <= top_bit;
            r_frac <= '0;
        end else if (r_busy) begin
            r_m    <= n_m;
            r_frac <= {r_frac[LOG_FRAC_W-2:0], frac_bit};
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = {r_int, r_frac};

endmodule

FILE: rtl/fdqm_div.sv
// restoring divider, one quotient bit per cycle
module fdqm_div #(
    parameter int W = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;

    logic [W:0]       trial;
    logic             fits;
    logic [W:0]       diff;

    assign trial = {r_rem, r_quo[W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[W-1:0] : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: rtl/frame_divergence_quality_meter_core.sv
// top level of the frame divergence meter: sequencer, frame store, log and divide units
// per item: only stored when there is nothing to compare with; otherwise compared in READ, and
//   a nonzero difference then goes through the 12-step log2 unit
// frame end adds FIN, the DW-bit restoring divide (DW = 18 at default depth) and 5 stages;
//   the output register lets the next item in while a result waits
// the frame store is one read-first single-port ram, read and written at the accept edge
// synchronous active-low reset clears control state and the configuration registers; the
//   frame store is not cleared, only entries already written are ever compared
module frame_divergence_quality_meter_core #(
    parameter int FRAME_DEPTH = fdqm_pkg::FRAME_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: feature_value [15:0], prior_exponent [31:16]
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fdqm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tlast,
    // tdata: exponent [15:0], quality [31:16], stable [32], degradation [34:33], zero fill
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fdqm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [fdqm_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [fdqm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    import fdqm_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int LW = $clog2(FRAME_DEPTH + 1);
    localparam int CW = (LW > MINP_W) ? LW : MINP_W;
    localparam int DW = ((LW > MAG_W + 1) ? LW : MAG_W + 1) + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(FRAME_DEPTH);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_LOG  = 4'd2;
    localparam logic [3:0] S_FIN  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_SMA  = 4'd5;
    localparam logic [3:0] S_SMB  = 4'd6;
    localparam logic [3:0] S_QA   = 4'd7;
    localparam logic [3:0] S_QB   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // quality curve segments
    localparam logic [1:0] R_FLAT = 2'd0;
    localparam logic [1:0] R_NEG  = 2'd1;
    localparam logic [1:0] R_POS  = 2'd2;
    localparam logic [1:0] R_ZERO = 2'd3;

    // reciprocals with 20 fraction bits, exact over the numerator ranges used
    localparam logic [17:0] RECIP_10 = 18'd104858;
    localparam logic [17:0] RECIP_5  = 18'd209716;

    // configuration
    logic [STAB_W-1:0]   r_stab_limit;
    logic [WEIGHT_W-1:0] r_weight;
    logic [MINP_W-1:0]   r_min_points;
    logic [LIMIT_W-1:0]  r_mild_limit;
    logic [LIMIT_W-1:0]  r_severe_limit;

    // sequencer and frame state
    logic [3:0]               r_state, n_state;
    logic signed [FEAT_W-1:0] r_cur, n_cur;
    logic                     r_last, n_last;
    logic signed [EXP_W-1:0]  r_prior, n_prior;
    logic [LW-1:0]            r_idx, n_idx;
    logic [LW-1:0]            r_sample_idx, n_sample_idx;
    logic [LW-1:0]            r_prev_len, n_prev_len;
    logic                     r_have_prev, n_have_prev;
    logic [LOG_W-1:0]         r_last_lg, n_last_lg;
    logic                     r_have_last, n_have_last;
    // the sum telescopes to last log minus first log, so it stays within one log range
    logic signed [SUM_W-1:0]  r_log_sum, n_log_sum;
    logic [AW-1:0]            r_pairs, n_pairs;

    // frame end datapath
    logic                     r_neg, n_neg;
    logic signed [EXP_W-1:0]  r_mean, n_mean;
    logic signed [25:0]       r_p1, n_p1;
    logic signed [25:0]       r_p2, n_p2;
    logic signed [EXP_W-1:0]  r_e, n_e;
    logic [1:0]               r_region, n_region;
    logic [QUAL_W-1:0]        r_qdiv, n_qdiv;
    logic [EXP_W-1:0]         r_res_exp, n_res_exp;
    logic [QUAL_W-1:0]        r_res_qual, n_res_qual;
    logic                     r_res_stab, n_res_stab;
    logic [DEG_W-1:0]         r_res_deg, n_res_deg;

    // output register
    logic                     r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data, n_out_data;

    // unit connections
    logic                     ram_we;
    logic [FEAT_W-1:0]        ram_rdata;
    t_log_req                 log_req;
    t_log_rsp                 log_rsp;
    logic                     div_start;
    logic [DW-1:0]            div_num;
    logic [DW-1:0]            div_den;
    logic                     div_done;
    logic [DW-1:0]            div_quot;

    // combinational helpers
    logic                     accept;
    logic                     in_range;
    logic                     do_cmp;
    logic signed [FEAT_W:0]   diff;
    logic [MAG_W-1:0]         delta;
    logic [LW-1:0]            cur_len;
    logic [LW-1:0]            compared;
    logic                     first_frame;
    logic                     enough;
    logic [SUM_W-1:0]         sum_abs;
    logic [MAG_W-1:0]         mag;
    logic [WEIGHT_W-1:0]      w_eff;
    logic signed [25:0]       mix;
    logic signed [17:0]       mix_sh;
    logic [16:0]              neg_e;
    logic [12:0]              pos_span;
    logic [17:0]              q_num;
    logic [17:0]              q_recip;
    logic [35:0]              q_prod;
    logic [16:0]              e_mag;
    logic [QUAL_W-1:0]        quality;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_range = r_sample_idx < DEPTH_L;
    assign do_cmp   = in_range && r_have_prev && (r_sample_idx < r_prev_len);
    assign ram_we   = accept && in_range;

    assign diff  = {ram_rdata[FEAT_W-1], ram_rdata} == {r_cur[FEAT_W-1], r_cur} ?
                   '0 : {r_cur[FEAT_W-1], r_cur} - {ram_rdata[FEAT_W-1], ram_rdata};
    assign delta = diff[FEAT_W] ? MAG_W'(-diff) : MAG_W'(diff);

    assign cur_len     = (r_idx < DEPTH_L) ? r_idx + 1'b1 : DEPTH_L;
    assign compared    = (cur_len < r_prev_len) ? cur_len : r_prev_len;
    assign first_frame = !r_have_prev || (r_prev_len == '0);
    assign enough      = (CW'(compared) >= CW'(r_min_points))
                      && (CW'(r_pairs) >= CW'(r_min_points >> 1))
                      && (r_pairs != '0);
    assign sum_abs     = r_log_sum[SUM_W-1] ? SUM_W'(-r_log_sum) : SUM_W'(r_log_sum);
    assign mag         = sum_abs[MAG_W-1:0];
    // rounded mean: (2|sum| + n) / 2n
    assign div_num     = DW'({mag, 1'b0}) + DW'(r_pairs);
    assign div_den     = DW'({r_pairs, 1'b0});
    assign div_start   = (r_state == S_FIN) && !first_frame && enough;

    // weights above one count as one
    assign w_eff  = (r_weight[WEIGHT_W-1] && (r_weight[WEIGHT_W-2:0] != '0)) ?
                    WEIGHT_W'(256) : r_weight;
    assign mix    = r_p1 + r_p2 + 26'sd128;
    assign mix_sh = mix[25:8];

    // quality curve numerators, then divide by 10 or 5 through the reciprocal
    assign neg_e    = 17'd0 - 17'(r_e);
    assign pos_span = 13'(17'sd4096 - 17'(r_e));
    always_comb begin
        q_num   = '0;
        q_recip = '0;
        if (r_e < -16'sd2048) begin
            n_region = R_FLAT;
        end else if (r_e < 16'sd0) begin
            n_region = R_NEG;
            q_num    = (18'(neg_e) << 3) + 18'd5;
            q_recip  = RECIP_10;
        end else if (r_e < 16'sd4096) begin
            n_region = R_POS;
            q_num    = (18'(pos_span) << 5) + (18'(pos_span) << 2)
                     + (18'(pos_span) << 1) + 18'd2;
            q_recip  = RECIP_5;
        end else begin
            n_region = R_ZERO;
        end
    end
    assign q_prod = 36'(q_num) * 36'(q_recip);
    assign n_qdiv = q_prod[35:20];

    assign e_mag = r_e[EXP_W-1] ? neg_e : 17'(r_e);
    always_comb begin
        unique case (r_region)
            R_FLAT:  quality = QUAL_ONE;
            R_NEG:   quality = QUAL_ONE - r_qdiv;
            R_POS:   quality = r_qdiv;
            default: quality = '0;
        endcase
    end

    assign log_req.start = (r_state == S_READ) && (delta != '0);
    assign log_req.delta = delta;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_last       = r_last;
        n_prior      = r_prior;
        n_idx        = r_idx;
        n_sample_idx = r_sample_idx;
        n_prev_len   = r_prev_len;
        n_have_prev  = r_have_prev;
        n_last_lg    = r_last_lg;
        n_have_last  = r_have_last;
        n_log_sum    = r_log_sum;
        n_pairs      = r_pairs;
        n_neg        = r_neg;
        n_mean       = r_mean;
        n_p1         = r_p1;
        n_p2         = r_p2;
        n_e          = r_e;
        n_res_exp    = r_res_exp;
        n_res_qual   = r_res_qual;
        n_res_stab   = r_res_stab;
        n_res_deg    = r_res_deg;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cur   = s_axis_tdata[FEAT_W-1:0];
                    n_last  = s_axis_tlast;
                    n_prior = s_axis_tdata[IN_TDATA_W-1:FEAT_W];
                    n_idx   = r_sample_idx;
                    if (in_range) begin
                        n_sample_idx = r_sample_idx + 1'b1;
                    end
                    if (do_cmp) begin
                        n_state = S_READ;
                    end else if (s_axis_tlast) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_READ: begin
                if (delta != '0) begin
                    n_state = S_LOG;
                end else begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_LOG: begin
                if (log_rsp.done) begin
                    if (r_have_last) begin
                        n_log_sum = r_log_sum + SUM_W'(log_rsp.value) - SUM_W'(r_last_lg);
                        n_pairs   = r_pairs + 1'b1;
                    end
                    n_last_lg   = log_rsp.value;
                    n_have_last = 1'b1;
                    n_state     = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                // the divider has taken its operands, so the frame state can roll over
                n_prev_len   = cur_len;
                n_have_prev  = 1'b1;
                n_sample_idx = '0;
                n_last_lg    = '0;
                n_have_last  = 1'b0;
                n_log_sum    = '0;
                n_pairs      = '0;
                n_neg        = r_log_sum[SUM_W-1];
                if (first_frame) begin
                    n_res_exp  = '0;
                    n_res_qual = QUAL_ONE;
                    n_res_stab = 1'b1;
                    n_res_deg  = DEG_NONE;
                    n_state    = S_OUT;
                end else if (enough) begin
                    n_state = S_DIV;
                end else begin
                    n_mean  = '0;
                    n_state = S_SMA;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_quot > DW'(32767)) begin
                        n_mean = r_neg ? -16'sd32768 : 16'sd32767;
                    end else begin
                        n_mean = r_neg ? -$signed(div_quot[EXP_W-1:0])
                                       : $signed(div_quot[EXP_W-1:0]);
                    end
                    n_state = S_SMA;
                end
            end
            S_SMA: begin
                n_p1    = $signed({1'b0, w_eff}) * r_mean;
                n_p2    = $signed({1'b0, WEIGHT_W'(256) - w_eff}) * r_prior;
                n_state = S_SMB;
            end
            S_SMB: begin
                if (r_prior != '0) begin
                    if (mix_sh > 18'sd32767) begin
                        n_e = 16'sd32767;
                    end else if (mix_sh < -18'sd32768) begin
                        n_e = -16'sd32768;
                    end else begin
                        n_e = mix_sh[EXP_W-1:0];
                    end
                end else begin
                    n_e = r_mean;
                end
                n_state = S_QA;
            end
            S_QA: begin
                n_state = S_QB;
            end
            S_QB: begin
                n_res_exp  = r_e;
                n_res_qual = quality;
                n_res_stab = e_mag < 17'(r_stab_limit);
                if (r_e[EXP_W-1]) begin
                    n_res_deg = DEG_NONE;
                end else if (quality > r_mild_limit) begin
                    n_res_deg = DEG_NONE;
                end else if (quality > r_severe_limit) begin
                    n_res_deg = DEG_MILD;
                end else begin
                    n_res_deg = DEG_SEVERE;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {5'd0, r_res_deg, r_res_stab, r_res_qual, r_res_exp};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sample_idx <= '0;
            r_prev_len   <= '0;
            r_have_prev  <= 1'b0;
            r_last_lg    <= '0;
            r_have_last  <= 1'b0;
            r_log_sum    <= '0;
            r_pairs      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sample_idx <= n_sample_idx;
            r_prev_len   <= n_prev_len;
            r_have_prev  <= n_have_prev;
            r_last_lg    <= n_last_lg;
            r_have_last  <= n_have_last;
            r_log_sum    <= n_log_sum;
            r_pairs      <= n_pairs;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_last     <= n_last;
        r_prior    <= n_prior;
        r_idx      <= n_idx;
        r_neg      <= n_neg;
        r_mean     <= n_mean;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_e        <= n_e;
        r_region   <= n_region;
        r_qdiv     <= n_qdiv;
        r_res_exp  <= n_res_exp;
        r_res_qual <= n_res_qual;
        r_res_stab <= n_res_stab;
        r_res_deg  <= n_res_deg;
        r_out_data <= n_out_data;
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stab_limit   <= STAB_LIMIT_RST;
            r_weight       <= WEIGHT_RST;
            r_min_points   <= MIN_POINTS_RST;
            r_mild_limit   <= MILD_LIMIT_RST;
            r_severe_limit <= SEVERE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_STAB_LIMIT:   r_stab_limit   <= i_cfg_wdata[STAB_W-1:0];
                REG_WEIGHT:       r_weight       <= i_cfg_wdata[WEIGHT_W-1:0];
                REG_MIN_POINTS:   r_min_points   <= i_cfg_wdata[MINP_W-1:0];
                REG_MILD_LIMIT:   r_mild_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                REG_SEVERE_LIMIT: r_severe_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // previous frame store: old sample read out while the new one is written
    fdqm_ram #(
        .W (FEAT_W),
        .D (FRAME_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_sample_idx[AW-1:0]),
        .i_wdata (s_axis_tdata[FEAT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    fdqm_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (log_req),
        .o_rsp   (log_rsp)
    );

    fdqm_div #(
        .W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/fdqm_checker.sv
// port-level assertions for the divergence meter, bound to the top level
module fdqm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fdqm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import fdqm_pkg::*;

    logic [QUAL_W-1:0] out_qual;
    logic [DEG_W-1:0]  out_deg;
    logic              out_exp_neg;

    assign out_qual    = m_axis_tdata[QUAL_LSB +: QUAL_W];
    assign out_deg     = m_axis_tdata[DEG_LSB +: DEG_W];
    assign out_exp_neg = m_axis_tdata[EXP_LSB + EXP_W - 1];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // frame end keeps the input closed while the result is worked out
    a_frame_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("item taken during frame end");

    a_deg_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_deg == DEG_NONE) || (out_deg == DEG_MILD)
                       || (out_deg == DEG_SEVERE))
        else $error("unknown degradation code");

    a_qual_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_qual <= QUAL_ONE)
        else $error("quality above one");

    // a negative exponent never reports degradation
    a_neg_no_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_exp_neg |-> out_deg == DEG_NONE)
        else $error("degradation on negative exponent");

endmodule

bind frame_divergence_quality_meter_core fdqm_checker u_fdqm_checker (.*);
